// ===== rtl/ofdu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofdu_pkg: shared types and constants of the frame buffer diff updater.
// Geometry, field widths, item kinds and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ofdu_pkg;

	localparam int NUM_COLUMNS = 128;
	localparam int NUM_ROWS    = 64;
	localparam int NUM_PAIRS   = NUM_COLUMNS / 2;
	localparam int COL_W       = $clog2(NUM_COLUMNS);
	localparam int ROW_W       = $clog2(NUM_ROWS);
	localparam int PAIR_W      = $clog2(NUM_PAIRS);
	// One memory word holds a column pair: even column low, odd column high.
	localparam int WORD_W      = 2 * NUM_ROWS;
	localparam int BIT_W       = ROW_W + 1;

	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 24;

	localparam logic [3:0] NIBBLE_ON = 4'hF;

	typedef enum logic [2:0] {
		KIND_POKE   = 3'd0,
		KIND_PEEK   = 3'd1,
		KIND_CLEAR  = 3'd2,
		KIND_RENDER = 3'd3,
		KIND_FRAME  = 3'd4
	} kind_t;

	localparam logic RES_ROW  = 1'b0;
	localparam logic RES_PEEK = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic accept;
		logic clear_draw;
		logic swap;
		logic write_back;
		logic load_peek;
		logic load_scan;
		logic emit_row;
		logic skip_row;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  out_free;
		logic  cur_bit;
		logic  mask_zero;
	} status_t;

endpackage

// ===== rtl/ofdu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofdu_ctrl: sequencing state machine.
// Accepts one word at a time, waits on the memory read and steps the row scan.
// ----------------------------------------------------------------------------
module ofdu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  ofdu_pkg::kind_t   in_kind,
	input  ofdu_pkg::status_t st,
	output logic              s_tready,
	output ofdu_pkg::cmd_t    cmd
);
	import ofdu_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (in_kind)
						KIND_POKE, KIND_PEEK, KIND_RENDER: state_d = ST_READ;
						default:                           state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: begin
				case (st.kind)
					KIND_PEEK:   state_d = st.out_free ? ST_IDLE : ST_READ;
					KIND_RENDER: state_d = ST_SCAN;
					default:     state_d = ST_IDLE;
				endcase
			end
			ST_SCAN: begin
				if (st.mask_zero) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready       = 1'b1;
				cmd.accept     = s_tvalid;
				cmd.clear_draw = s_tvalid && (in_kind == KIND_CLEAR);
				cmd.swap       = s_tvalid && (in_kind == KIND_FRAME);
			end
			ST_READ: begin
				cmd.write_back = (st.kind == KIND_POKE);
				cmd.load_peek  = (st.kind == KIND_PEEK) && st.out_free;
				cmd.load_scan  = (st.kind == KIND_RENDER);
			end
			ST_SCAN: begin
				if (!st.mask_zero) begin
					cmd.emit_row = st.cur_bit && st.out_free;
					cmd.skip_row = !st.cur_bit;
				end
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/ofdu_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofdu_datapath: frame memories, dirty-row scan and output register.
// Two pair-organized memories with per-word valid bits, swapped by a role bit.
// ----------------------------------------------------------------------------
module ofdu_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [ofdu_pkg::IN_DATA_W-1:0]    s_tdata,
	input  ofdu_pkg::kind_t                   in_kind,
	input  ofdu_pkg::cmd_t                    cmd,
	output ofdu_pkg::status_t                 st,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ofdu_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tuser,
	output logic                              m_tlast
);
	import ofdu_pkg::*;

	logic [WORD_W-1:0] mem0 [NUM_PAIRS];
	logic [WORD_W-1:0] mem1 [NUM_PAIRS];
	logic [NUM_PAIRS-1:0] valid0_q;
	logic [NUM_PAIRS-1:0] valid1_q;
	logic draw_sel_q;    // 0: memory 0 is the drawing buffer

	logic [WORD_W-1:0] rd0_s1;
	logic [WORD_W-1:0] rd1_s1;
	logic              vld0_s1;
	logic              vld1_s1;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             val_q;
	kind_t            kind_q;

	logic [NUM_ROWS-1:0] mask_q;
	logic [NUM_ROWS-1:0] even_q;
	logic [NUM_ROWS-1:0] odd_q;
	logic [ROW_W-1:0]    scan_row_q;

	logic                  out_valid_q;
	logic                  res_kind_q;
	logic [PAIR_W-1:0]     col_addr_q;
	logic [ROW_W-1:0]      row_addr_q;
	logic [7:0]            byte_q;
	logic                  peek_q;
	logic                  last_q;

	logic [COL_W-1:0]  in_col;
	logic [PAIR_W-1:0] rd_addr;
	logic [PAIR_W-1:0] wr_addr;
	logic [WORD_W-1:0] word0;
	logic [WORD_W-1:0] word1;
	logic [WORD_W-1:0] draw_word;
	logic [WORD_W-1:0] shown_word;
	logic [WORD_W-1:0] poke_word;
	logic [NUM_ROWS-1:0] changed;
	logic [BIT_W-1:0]    bit_idx;
	logic [NUM_ROWS-1:0] row_onehot;
	logic [NUM_ROWS-1:0] mask_next;
	logic                out_free;

	assign in_col  = s_tdata[COL_W-1:0];
	assign rd_addr = in_col[COL_W-1:1];
	assign wr_addr = col_q[COL_W-1:1];
	assign bit_idx = {col_q[0], row_q};

	assign word0      = vld0_s1 ? rd0_s1 : '0;
	assign word1      = vld1_s1 ? rd1_s1 : '0;
	assign draw_word  = draw_sel_q ? word1 : word0;
	assign shown_word = draw_sel_q ? word0 : word1;
	assign changed    = (draw_word[NUM_ROWS-1:0] ^ shown_word[NUM_ROWS-1:0])
	                  | (draw_word[WORD_W-1:NUM_ROWS] ^ shown_word[WORD_W-1:NUM_ROWS]);

	always_comb begin
		poke_word          = draw_word;
		poke_word[bit_idx] = val_q;
	end

	assign row_onehot = {{(NUM_ROWS-1){1'b0}}, 1'b1} << scan_row_q;
	assign mask_next  = mask_q & ~row_onehot;
	assign out_free   = !out_valid_q || m_tready;

	assign st.kind      = kind_q;
	assign st.out_free  = out_free;
	assign st.cur_bit   = mask_q[scan_row_q];
	assign st.mask_zero = (mask_q == '0);

	// Memory read and write ports.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd0_s1 <= mem0[rd_addr];
			rd1_s1 <= mem1[rd_addr];
		end
		if (cmd.write_back && !draw_sel_q) begin
			mem0[wr_addr] <= poke_word;
		end
		if (cmd.write_back && draw_sel_q) begin
			mem1[wr_addr] <= poke_word;
		end
	end

	// Valid bits and buffer roles.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid0_q   <= '0;
			valid1_q   <= '0;
			draw_sel_q <= 1'b0;
			vld0_s1    <= 1'b0;
			vld1_s1    <= 1'b0;
		end else begin
			if (cmd.accept) begin
				vld0_s1 <= valid0_q[rd_addr];
				vld1_s1 <= valid1_q[rd_addr];
			end
			if (cmd.swap) begin
				draw_sel_q <= !draw_sel_q;
			end
			if ((cmd.clear_draw && !draw_sel_q) || (cmd.swap && draw_sel_q)) begin
				valid0_q <= '0;
			end
			if ((cmd.clear_draw && draw_sel_q) || (cmd.swap && !draw_sel_q)) begin
				valid1_q <= '0;
			end
			if (cmd.write_back && !draw_sel_q) begin
				valid0_q[wr_addr] <= 1'b1;
			end
			if (cmd.write_back && draw_sel_q) begin
				valid1_q[wr_addr] <= 1'b1;
			end
		end
	end

	// Item fields and scan registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			col_q  <= in_col;
			row_q  <= s_tdata[COL_W+ROW_W-1:COL_W];
			val_q  <= s_tdata[COL_W+ROW_W];
			kind_q <= in_kind;
		end
		if (cmd.load_scan) begin
			even_q <= draw_word[NUM_ROWS-1:0];
			odd_q  <= draw_word[WORD_W-1:NUM_ROWS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q     <= '0;
			scan_row_q <= '0;
		end else begin
			if (cmd.load_scan) begin
				mask_q     <= changed;
				scan_row_q <= '0;
			end else if (cmd.emit_row) begin
				mask_q     <= mask_next;
				scan_row_q <= scan_row_q + 1'b1;
			end else if (cmd.skip_row) begin
				scan_row_q <= scan_row_q + 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_peek || cmd.emit_row) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_peek) begin
			res_kind_q <= RES_PEEK;
			col_addr_q <= '0;
			row_addr_q <= '0;
			byte_q     <= '0;
			peek_q     <= draw_word[bit_idx];
			last_q     <= 1'b1;
		end else if (cmd.emit_row) begin
			res_kind_q <= RES_ROW;
			col_addr_q <= col_q[COL_W-1:1];
			row_addr_q <= scan_row_q;
			byte_q     <= {odd_q[scan_row_q] ? NIBBLE_ON : 4'h0,
			               even_q[scan_row_q] ? NIBBLE_ON : 4'h0};
			peek_q     <= 1'b0;
			last_q     <= (mask_next == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{(OUT_DATA_W-PAIR_W-ROW_W-9){1'b0}}, peek_q, byte_q,
	                   row_addr_q, col_addr_q};

endmodule

// ===== rtl/oled_framebuffer_diff_updater.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oled_framebuffer_diff_updater: double-buffered 1-bit frame store.
// Draws into one 128x64 buffer, compares it against the shown one per column
// pair and streams out row writes for the rows that changed.
// ----------------------------------------------------------------------------
// The block takes one word at a time. Poke and peek each first read the
// column-pair word from the frame memories, then modify and write it back or
// load the answer into the output register (a peek waits there while an
// earlier result is still unclaimed). Clear, new frame and unknown kinds
// finish in the accepting cycle, because each memory word has a valid bit and
// clearing a buffer just drops all its valid bits at once; no clearing pass
// runs after reset. A render accepts the word, reads the column-pair word and
// then scans the rows up to the last changed row (at most 64), stopping once
// it sees the dirty mask empty; the row scan counter inspects one row per
// cycle but holds on a changed row while the output register is not free.
// Row writes come out in rising row order and the last one carries tlast; a
// render with no changed row gives no word.
module oled_framebuffer_diff_updater (
	input  logic                             clk,
	input  logic                             arst_n,
	// s_tdata fields from bit 0 up: column[6:0], row[12:7], pixel_value[13].
	input  logic [ofdu_pkg::IN_DATA_W-1:0]   s_tdata,
	// s_tuser fields from bit 0 up: kind[2:0].
	input  logic [2:0]                       s_tuser,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// m_tdata fields from bit 0 up: column_address[5:0], row_address[11:6],
	// pixel_byte[19:12], peek_value[20], zero fill[23:21].
	output logic [ofdu_pkg::OUT_DATA_W-1:0]  m_tdata,
	// m_tuser fields from bit 0 up: result_kind[0].
	output logic                             m_tuser,
	output logic                             m_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready
);
	import ofdu_pkg::*;

	cmd_t    cmd;
	status_t st;
	kind_t   in_kind;

	// The kind decodes to no member for codes 5 to 7; the case statements
	// downstream send those to their default arms, which do nothing.
	assign in_kind = kind_t'(s_tuser);

	ofdu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.in_kind  (in_kind),
		.st       (st),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	ofdu_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.in_kind  (in_kind),
		.cmd      (cmd),
		.st       (st),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// A row write is only issued for a set dirty bit into a free output register.
	a_emit_guarded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_row |-> (st.cur_bit && st.out_free && !st.mask_zero))
		else $error("row write issued without a free output or a dirty row");

	// A peek answer never overwrites an unclaimed result.
	a_peek_guarded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_peek |-> st.out_free)
		else $error("peek answer loaded over a pending result");

	// A peek answer is always the single, final word of its item.
	a_peek_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == RES_PEEK)) |-> (m_tlast && (m_tdata[19:0] == '0)))
		else $error("peek answer without tlast or with row write fields");

	// New words are taken only while nothing of an earlier item is in flight.
	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !(cmd.write_back || cmd.load_peek || cmd.load_scan
		                 || cmd.emit_row || cmd.skip_row))
		else $error("word accepted while an earlier item is still at work");

endmodule
